@@ rtl/smds_pkg.sv @@
// package for the signed multiply/divide sequencer
// holds phase enum, code constants and the phase transition function
`timescale 1ns / 1ps

package smds_pkg;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_P1    = 4'd1,
        PH_P2    = 4'd2,
        PH_P3    = 4'd3,
        PH_MUL   = 4'd4,
        PH_DIV   = 4'd5,
        PH_P6    = 4'd6,
        PH_P7    = 4'd7,
        PH_MDONE = 4'd8,
        PH_P9    = 4'd9,
        PH_DDONE = 4'd10,
        PH_P11   = 4'd11,
        PH_P12   = 4'd12,
        PH_P13   = 4'd13,
        PH_P14   = 4'd14,
        PH_P15   = 4'd15
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_MFIN,
        ST_DIV,
        ST_DFIN,
        ST_OUT
    } t_state;

    localparam logic [2:0] CMD_DIV  = 3'd4;
    localparam logic [2:0] CMD_LDX  = 3'd5;
    localparam logic [2:0] CMD_LDXZ = 3'd6;
    localparam logic [2:0] CMD_READ = 3'd7;

    localparam logic [15:0] CODE_CLR  = 16'h6666;
    localparam logic [15:0] CODE_M0   = 16'h0000;
    localparam logic [15:0] CODE_M60  = 16'h0060;
    localparam logic [15:0] CODE_M61  = 16'h0061;
    localparam logic [15:0] CODE_M2   = 16'h0002;
    localparam logic [15:0] CODE_M62  = 16'h0062;
    localparam logic [15:0] CODE_M6660 = 16'h6660;
    localparam logic [15:0] CODE_M3   = 16'h0003;
    localparam logic [15:0] CODE_M63  = 16'h0063;
    localparam logic [15:0] CODE_M660 = 16'h0660;
    localparam logic [15:0] CODE_M661 = 16'h0661;
    localparam logic [15:0] CODE_M662 = 16'h0662;
    localparam logic [15:0] CODE_D4   = 16'h0004;
    localparam logic [15:0] CODE_D664 = 16'h0664;
    localparam logic [15:0] CODE_D6664 = 16'h6664;

    function automatic t_phase next_phase(input t_phase p, input logic [2:0] d);
        t_phase r;
        r = PH_IDLE;
        unique case (p)
            PH_IDLE:  r = (d < 3'd4) ? PH_MUL : (d == 3'd4) ? PH_DIV :
                          (d == 3'd7) ? PH_IDLE : PH_P1;
            PH_P1:    r = (d < 3'd4) ? PH_MUL : (d == 3'd6) ? PH_P3 :
                          (d == 3'd7) ? PH_IDLE : PH_DIV;
            PH_P3:    r = (d < 3'd4) ? PH_MUL : (d == 3'd6) ? PH_P11 :
                          (d == 3'd7) ? PH_IDLE : PH_DIV;
            PH_MUL:   r = PH_MDONE;
            PH_DIV:   r = PH_DDONE;
            PH_MDONE: r = (d < 3'd4) ? PH_MUL : (d == 3'd4) ? PH_DIV :
                          (d == 3'd6) ? PH_P1 : PH_IDLE;
            PH_DDONE: r = (d < 3'd5) ? PH_MUL : (d == 3'd5) ? PH_DIV :
                          (d == 3'd6) ? PH_P1 : PH_IDLE;
            PH_P11:   r = (d < 3'd4) ? PH_MUL : (d == 3'd6) ? PH_P1 :
                          (d == 3'd7) ? PH_IDLE : PH_DIV;
            default:  r = PH_IDLE;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/signed_mul_div_sequencer_unit.sv @@
// top level of the signed multiply/divide sequencer
// uses smds_pkg; one shared 33-bit add/subtract unit for multiply and divide
`timescale 1ns / 1ps

// One request is taken at a time. A load or read is accepted and its result then
// sits in the output register. A multiply runs 16 shift-add steps on the shared
// adder and a divide by a nonzero divisor 32 restoring steps. Input stall is high
// while a request is in work or its result has not been taken. Each request
// returns exactly one result.
module signed_mul_div_sequencer_unit
    import smds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_data_in,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_read_data,
    output logic        o_read_valid
);

    t_state      r_state, n_state;
    t_phase      r_phase;
    logic [15:0] r_x, r_y, r_code;
    logic        r_long, r_half;
    logic [31:0] r_zw;
    logic [15:0] r_rdata;
    logic        r_rvalid;
    logic [5:0]  r_cnt;
    logic [31:0] r_acc;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [31:0] r_mag;
    logic [15:0] r_dvs;
    logic        r_qneg, r_rneg;

    logic        w_acc;
    logic [32:0] w_sum;
    logic [32:0] w_a, w_b;
    logic        w_sub;

    assign w_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_read_data  = r_rdata;
    assign o_read_valid = r_rvalid;

    // shared adder
    assign w_sum = w_sub ? (w_a - w_b) : (w_a + w_b);

    always_comb begin
        w_a = '0;
        w_b = '0;
        w_sub = 1'b0;
        if (r_state == ST_MUL) begin
            w_a = {1'b0, r_acc};
            w_b = r_y[r_cnt[3:0]] ? {1'b0, 16'(signed'(r_x) >>> 16), r_x} << r_cnt[3:0]
                                  : 33'd0;
            w_sub = (r_cnt[3:0] == 4'd15) && r_y[15];
        end else if (r_state == ST_DIV) begin
            w_a = {r_rem[31:0], r_mag[31]};
            w_b = {17'd0, r_dvs};
            w_sub = 1'b1;
        end
    end

    function automatic logic code_is(input logic [15:0] c, input logic lg,
                                     input logic [15:0] k);
        return !lg && (c == k);
    endfunction

    logic [15:0] w_code;
    logic        w_long;
    t_phase      w_ph;
    logic        w_rd;
    logic [15:0] w_rv;
    logic [15:0] w_base;
    logic [15:0] w_nx, w_ny;
    logic [31:0] w_nzw;
    logic        w_nhalf;
    logic        w_act;

    always_comb begin
        w_base = r_code;
        w_long = r_long;
        w_nx = r_x;
        w_ny = r_y;
        w_nzw = r_zw;
        w_nhalf = r_half;
        w_rd = 1'b0;
        w_rv = 16'd0;
        w_act = 1'b1;
        if (r_phase == PH_IDLE || r_phase == PH_MDONE || r_phase == PH_DDONE) begin
            w_base = 16'd0;
            w_long = 1'b0;
        end else if (r_phase == PH_P1 && code_is(r_code, r_long, CODE_CLR)) begin
            w_base = 16'd0;
            w_long = 1'b0;
        end
        if (w_base[15:12] != 4'd0) w_long = 1'b1;
        w_code = {w_base[11:0], 1'b0, i_cmd};
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cmd < CMD_DIV) w_ny = i_data_in;
                else if (i_cmd == CMD_LDX || i_cmd == CMD_LDXZ) w_nx = i_data_in;
                else if (i_cmd == CMD_READ) w_rd = 1'b1;
            end
            PH_MDONE, PH_DDONE: begin
                if (i_cmd < CMD_DIV) w_ny = i_data_in;
                else if (i_cmd == CMD_LDXZ) w_nx = i_data_in;
                else if (i_cmd == CMD_READ) w_rd = 1'b1;
            end
            PH_P1: begin
                if (i_cmd < CMD_DIV) w_ny = i_data_in;
                else if (i_cmd == CMD_LDXZ) w_nzw = {i_data_in, r_zw[15:0]};
            end
            PH_P3: begin
                if (i_cmd < CMD_DIV) w_ny = i_data_in;
                else if (i_cmd == CMD_DIV || i_cmd == CMD_LDXZ)
                    w_nzw = {r_zw[31:16], i_data_in};
                else if (i_cmd == CMD_READ) w_rd = 1'b1;
            end
            PH_P11: begin
                if (i_cmd < CMD_DIV) w_ny = i_data_in;
                else if (i_cmd == CMD_READ) w_nzw = {16'd0, r_zw[15:0]};
            end
            default: w_act = 1'b0;
        endcase
        if (w_rd) begin
            w_rv = r_half ? r_zw[15:0] : r_zw[31:16];
            w_nhalf = !r_half;
        end
        w_ph = w_act ? next_phase(r_phase, i_cmd) : r_phase;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_acc) begin
                if (w_ph == PH_MUL) n_state = ST_MUL;
                else if (w_ph == PH_DIV && w_nx != 16'd0) n_state = ST_DIV;
                else n_state = ST_OUT;
            end
            ST_MUL:  if (r_cnt[3:0] == 4'd15) n_state = ST_MFIN;
            ST_MFIN: n_state = ST_OUT;
            ST_DIV:  if (r_cnt == 6'd31) n_state = ST_DFIN;
            ST_DFIN: n_state = ST_OUT;
            ST_OUT:  if (!i_stall) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // multiply result selection from finished product in r_acc
    logic [31:0] w_mres;
    always_comb begin
        w_mres = r_zw;
        if (code_is(r_code, r_long, CODE_M0) || code_is(r_code, r_long, CODE_M60))
            w_mres = r_acc;
        else if (code_is(r_code, r_long, CODE_M61))
            w_mres = 32'd0 - r_acc;
        else if (code_is(r_code, r_long, CODE_M2) || code_is(r_code, r_long, CODE_M62)
                 || code_is(r_code, r_long, CODE_M6660))
            w_mres = r_zw + r_acc;
        else if (code_is(r_code, r_long, CODE_M3) || code_is(r_code, r_long, CODE_M63))
            w_mres = r_zw - r_acc;
        else if (code_is(r_code, r_long, CODE_M660))
            w_mres = r_acc + {r_zw[31:16], 16'd0};
        else if (code_is(r_code, r_long, CODE_M661) || code_is(r_code, r_long, CODE_M662))
            w_mres = (32'd0 - r_acc) + {r_zw[31:16], 16'd0};
    end

    logic [31:0] w_q, w_r;
    logic        w_big;
    assign w_q = r_qneg ? 32'd0 - r_quo : r_quo;
    assign w_r = r_rneg ? 32'd0 - r_rem : r_rem;
    assign w_big = !r_qneg && (r_quo[31:16] != 16'd0) && (r_quo != 32'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_phase  <= PH_IDLE;
            r_x      <= '0;
            r_y      <= '0;
            r_zw     <= '0;
            r_code   <= '0;
            r_long   <= 1'b0;
            r_half   <= 1'b0;
            r_rvalid <= 1'b0;
            r_rdata  <= '0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: if (w_acc) begin
                    r_x <= w_nx;
                    r_y <= w_ny;
                    r_rdata <= w_rv;
                    r_rvalid <= w_rd;
                    r_cnt <= '0;
                    if (w_act) begin
                        r_code <= w_code;
                        r_long <= w_long;
                    end
                    if (w_ph == PH_MUL) begin
                        r_phase <= PH_MDONE;
                        r_zw <= w_nzw;
                        r_half <= w_nhalf;
                        r_acc <= '0;
                    end else if (w_ph == PH_DIV) begin
                        r_phase <= PH_DDONE;
                        r_half <= 1'b0;
                        if (w_nx == 16'd0) begin
                            r_zw <= 32'hffffffff;
                        end else begin
                            r_zw <= w_nzw;
                            r_dvs <= w_nx[15] ? 16'd0 - w_nx : w_nx;
                            if (code_is(w_code, w_long, CODE_D4)
                                || code_is(w_code, w_long, CODE_D664)) begin
                                r_mag <= w_nzw[31] ? 32'd0 - w_nzw : w_nzw;
                                r_qneg <= w_nzw[31] ^ w_nx[15];
                                r_rneg <= w_nzw[31];
                            end else if (code_is(w_code, w_long, CODE_D6664)) begin
                                r_mag <= {16'd0, w_nzw[15:0]};
                                r_qneg <= w_nx[15];
                                r_rneg <= 1'b0;
                            end else begin
                                r_mag <= '0;
                                r_qneg <= 1'b0;
                                r_rneg <= 1'b0;
                            end
                            r_rem <= '0;
                            r_quo <= '0;
                        end
                    end else begin
                        r_phase <= w_ph;
                        r_zw <= w_nzw;
                        r_half <= w_nhalf;
                    end
                end
                ST_MUL: begin
                    r_acc <= w_sum[31:0];
                    r_cnt <= r_cnt + 6'd1;
                end
                ST_MFIN: begin
                    r_zw <= w_mres;
                    r_half <= 1'b0;
                end
                ST_DIV: begin
                    if (!w_sum[32]) begin
                        r_rem <= w_sum[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end else begin
                        r_rem <= {r_rem[30:0], r_mag[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end
                    r_mag <= {r_mag[30:0], 1'b0};
                    r_cnt <= r_cnt + 6'd1;
                end
                ST_DFIN: begin
                    r_zw <= {w_q[15:8] | {8{w_big}}, w_q[7:0], w_r[15:0]};
                end
                default: ;
            endcase
        end
    end

`ifndef SYNTHESIS
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_read_data))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL || r_state == ST_DIV) |-> o_stall && !o_valid)
        else $error("accepting while busy");
    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_MUL |-> r_cnt < 6'd16)
        else $error("multiply step count overrun");
`endif

endmodule

@@ tb/smds_checker.sv @@
// request/result checker for the signed multiply/divide sequencer
// predicts read results per accepted request and compares them; uses smds_pkg
`timescale 1ns / 1ps

module smds_checker
    import smds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_stall_in,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_data_in,
    input  logic        i_valid_out,
    input  logic        i_stall_out,
    input  logic [15:0] i_read_data,
    input  logic        i_read_valid,
    output int          o_errors,
    output int          o_pending,
    output int          o_reads,
    output int          o_mults,
    output int          o_divs
);

    typedef struct packed {
        logic [15:0] rdata;
        logic        rvalid;
    } t_readout;

    t_readout    readout_q[$];
    logic [15:0] reg_x, reg_y, code;
    logic [31:0] reg_zw;
    logic        code_long, toggle;
    logic [3:0]  ph;

    function automatic logic [3:0] phase_after(input logic [3:0] p, input logic [2:0] d);
        logic [3:0] r;
        r = 4'd0;
        case (p)
            4'd0:  r = (d < 3'd4) ? 4'd4 : (d == 3'd4) ? 4'd5 : (d == CMD_READ) ? 4'd0 : 4'd1;
            4'd1:  r = (d < 3'd4) ? 4'd4 : (d == CMD_LDXZ) ? 4'd3 :
                       (d == CMD_READ) ? 4'd0 : 4'd5;
            4'd3:  r = (d < 3'd4) ? 4'd4 : (d == CMD_LDXZ) ? 4'd11 :
                       (d == CMD_READ) ? 4'd0 : 4'd5;
            4'd8:  r = (d < 3'd4) ? 4'd4 : (d == CMD_DIV) ? 4'd5 :
                       (d == CMD_LDXZ) ? 4'd1 : 4'd0;
            4'd10: r = (d < 3'd5) ? 4'd4 : (d == CMD_LDX) ? 4'd5 :
                       (d == CMD_LDXZ) ? 4'd1 : 4'd0;
            4'd11: r = (d < 3'd4) ? 4'd4 : (d == CMD_LDXZ) ? 4'd1 :
                       (d == CMD_READ) ? 4'd0 : 4'd5;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic logic code_hit(input logic [15:0] c);
        return !code_long && code == c;
    endfunction

    task automatic push_digit(input logic [2:0] d);
        if (code[15:12] != 4'd0) code_long = 1'b1;
        code = {code[11:0], 1'b0, d};
    endtask

    task automatic run_multiply();
        logic [31:0] p, n;
        p = 32'($signed(reg_x) * $signed(reg_y));
        n = -p;
        if (code_hit(CODE_M0) || code_hit(CODE_M60)) reg_zw = p;
        else if (code_hit(CODE_M61)) reg_zw = n;
        else if (code_hit(CODE_M2) || code_hit(CODE_M62) || code_hit(CODE_M6660))
            reg_zw = reg_zw + p;
        else if (code_hit(CODE_M3) || code_hit(CODE_M63)) reg_zw = reg_zw + n;
        else if (code_hit(CODE_M660)) reg_zw = p + (reg_zw & 32'hffff0000);
        else if (code_hit(CODE_M661) || code_hit(CODE_M662))
            reg_zw = n + (reg_zw & 32'hffff0000);
        toggle = 1'b0;
        o_mults++;
    endtask

    task automatic run_divide();
        longint q, r, num, den;
        logic [31:0] zq;
        q = 0;
        r = 0;
        den = longint'($signed(reg_x));
        toggle = 1'b0;
        o_divs++;
        if (den == 0) begin
            reg_zw = 32'hffffffff;
        end else begin
            if (code_hit(CODE_D4) || code_hit(CODE_D664)) begin
                num = longint'($signed(reg_zw));
                q = num / den;
                r = num % den;
            end else if (code_hit(CODE_D6664)) begin
                num = longint'(reg_zw[15:0]);
                q = num / den;
                r = num % den;
            end
            zq = q[31:0];
            if (q > 65535) zq[15:8] = 8'hff;
            reg_zw = {zq[15:0], r[15:0]};
        end
    endtask

    task automatic step_phase(input logic [2:0] d);
        ph = phase_after(ph, d);
        if (ph == 4'd4) begin
            run_multiply();
            ph = 4'd8;
        end else if (ph == 4'd5) begin
            run_divide();
            ph = 4'd10;
        end
    endtask

    task automatic take_half(inout t_readout e);
        e.rdata = toggle ? reg_zw[15:0] : reg_zw[31:16];
        e.rvalid = 1'b1;
        toggle = !toggle;
        o_reads++;
    endtask

    task automatic predict_request(input logic [2:0] d, input logic [15:0] w);
        t_readout e;
        e = '0;
        case (ph)
            4'd0: begin
                code = 16'd0;
                code_long = 1'b0;
                push_digit(d);
                if (d < 3'd4) begin
                    reg_y = w;
                    step_phase(d);
                end else if (d == CMD_DIV) begin
                    step_phase(d);
                end else if (d < CMD_READ) begin
                    reg_x = w;
                    step_phase(d);
                end else begin
                    take_half(e);
                end
            end
            4'd8, 4'd10: begin
                code = 16'd0;
                code_long = 1'b0;
                push_digit(d);
                if (d < 3'd4) reg_y = w;
                else if (d == CMD_LDXZ) reg_x = w;
                else if (d == CMD_READ) take_half(e);
                step_phase(d);
            end
            4'd1: begin
                if (code_hit(CODE_CLR)) begin
                    code = 16'd0;
                    code_long = 1'b0;
                end
                push_digit(d);
                if (d < 3'd4) reg_y = w;
                else if (d == CMD_LDXZ) reg_zw[31:16] = w;
                step_phase(d);
            end
            4'd3: begin
                push_digit(d);
                if (d < 3'd4) reg_y = w;
                else if (d == CMD_DIV || d == CMD_LDXZ) reg_zw[15:0] = w;
                else if (d == CMD_READ) take_half(e);
                step_phase(d);
            end
            4'd11: begin
                push_digit(d);
                if (d < 3'd4) reg_y = w;
                else if (d == CMD_READ) reg_zw[31:16] = 16'd0;
                step_phase(d);
            end
            default: ;
        endcase
        readout_q.push_back(e);
    endtask

    always @(posedge i_clk) begin
        t_readout e;
        if (!i_rst_n) begin
            reg_x = '0; reg_y = '0; reg_zw = '0; code = '0;
            code_long = 1'b0; ph = 4'd0; toggle = 1'b0;
            readout_q.delete();
            o_errors = 0; o_reads = 0; o_mults = 0; o_divs = 0;
            o_pending = 0;
        end else begin
            if (i_valid_out && !i_stall_out) begin
                if (readout_q.size() == 0) begin
                    $error("unexpected result read_data=%h", i_read_data);
                    o_errors++;
                end else begin
                    e = readout_q.pop_front();
                    if (i_read_data !== e.rdata) begin
                        $error("read_data expected %h actual %h", e.rdata, i_read_data);
                        o_errors++;
                    end
                    if (i_read_valid !== e.rvalid) begin
                        $error("read_valid expected %b actual %b", e.rvalid, i_read_valid);
                        o_errors++;
                    end
                end
            end
            if (i_valid && !i_stall_in) predict_request(i_cmd, i_data_in);
            o_pending = readout_q.size();
        end
    end

endmodule

@@ tb/tb.sv @@
// testbench top for signed_mul_div_sequencer_unit
// drives requests under several idle/stall mixes; checking is done in smds_checker
`timescale 1ns / 1ps

module tb;
    import smds_pkg::*;

    logic        clk, rst_n, in_valid, in_stall, out_valid, out_stall, rd_valid;
    logic [2:0]  cmd;
    logic [15:0] data_w, rd_data;
    int          errors, pending, reads, mults, divs, cycles;
    int          idle_pct, stall_pct;
    int          sent;

    signed_mul_div_sequencer_unit dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .o_stall(in_stall),
        .i_cmd(cmd), .i_data_in(data_w), .o_valid(out_valid), .i_stall(out_stall),
        .o_read_data(rd_data), .o_read_valid(rd_valid)
    );

    smds_checker chk (
        .i_clk(clk), .i_rst_n(rst_n), .i_valid(in_valid), .i_stall_in(in_stall),
        .i_cmd(cmd), .i_data_in(data_w), .i_valid_out(out_valid),
        .i_stall_out(out_stall), .i_read_data(rd_data), .i_read_valid(rd_valid),
        .o_errors(errors), .o_pending(pending), .o_reads(reads),
        .o_mults(mults), .o_divs(divs)
    );

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(negedge clk) begin
        out_stall <= rst_n && ($urandom_range(99) < stall_pct);
    end

    function automatic logic [15:0] pick_word();
        case ($urandom_range(5))
            0: return 16'h0000;
            1: return 16'hffff;
            2: return 16'h8000;
            3: return 16'h7fff;
            4: return 16'($urandom_range(15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [2:0] c, input logic [15:0] w);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        data_w <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
        @(negedge clk);
    endtask

    task automatic send_sequence();
        int k;
        case ($urandom_range(9))
            0: send_request(3'($urandom_range(3)), pick_word());
            1: begin
                send_request(CMD_LDX, pick_word());
                send_request(3'($urandom_range(3)), pick_word());
            end
            2: begin
                send_request(CMD_LDX, pick_word());
                send_request(CMD_LDXZ, pick_word());
                send_request(3'($urandom_range(4)), pick_word());
            end
            3: begin
                send_request(CMD_LDXZ, pick_word());
                send_request(CMD_LDXZ, pick_word());
                send_request(CMD_LDXZ, pick_word());
                send_request(3'($urandom_range(7)), pick_word());
            end
            4: begin
                send_request(CMD_LDX, pick_word());
                send_request(CMD_DIV, pick_word());
            end
            5: begin
                send_request(CMD_LDXZ, pick_word());
                send_request(CMD_LDXZ, pick_word());
                send_request(CMD_DIV, pick_word());
            end
            6, 7: begin
                send_request(CMD_READ, pick_word());
                send_request(CMD_READ, pick_word());
            end
            default: begin
                for (k = 0; k < 3; k++) send_request(3'($urandom_range(7)), pick_word());
            end
        endcase
    endtask

    initial begin
        int p;
        cycles = 0;
        sent = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = '0;
        data_w = '0;
        out_stall = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: operand extremes, each operation, zero divide, overflow, long code
        send_request(CMD_LDX, 16'h8000);
        send_request(3'd0, 16'h8000);
        send_request(CMD_READ, 16'h0);
        send_request(CMD_READ, 16'h0);
        send_request(CMD_LDX, 16'hffff);
        send_request(CMD_DIV, 16'h0);
        send_request(CMD_READ, 16'h0);
        send_request(CMD_READ, 16'h0);
        send_request(CMD_LDX, 16'h0000);
        send_request(CMD_DIV, 16'h0);
        send_request(CMD_READ, 16'hffff);
        send_request(CMD_LDXZ, 16'h7fff);
        send_request(CMD_LDXZ, 16'h1234);
        send_request(CMD_LDXZ, 16'h8001);
        send_request(3'd2, 16'h7fff);
        send_request(CMD_LDXZ, 16'h0003);
        send_request(CMD_LDXZ, 16'h0);
        send_request(CMD_LDXZ, 16'h5678);
        send_request(CMD_READ, 16'h0);
        send_request(CMD_LDXZ, 16'h0);
        send_request(CMD_LDXZ, 16'h0);
        send_request(3'd3, 16'hffff);
        send_request(CMD_READ, 16'h0);
        send_request(CMD_READ, 16'h0);

        sent = 0;
        for (p = 0; p < 4; p++) begin
            case (p)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 62; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 62; end
                default: begin idle_pct = 7; stall_pct = 7; end
            endcase
            while (sent < (p + 1) * 170) begin
                send_sequence();
            end
            // drain before the next mix
            in_valid <= 1'b0;
            while (pending != 0) @(negedge clk);
        end

        while (pending != 0) @(negedge clk);
        repeat (60) @(negedge clk);
        $display("covered %0d reads, %0d multiplies, %0d divides", reads, mults, divs);
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
